/* rtl/kht_pkg.sv */
// Shared types and codes for the key-to-id hash table.
package kht_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    localparam int KEY_W    = 32;
    localparam int ID_W     = 10;
    localparam int STATUS_W = 3;

    typedef struct packed {
        logic       load;
        logic       sweep_wr;
        logic       mod_step;
        logic       head_rd;
        logic       node_rd_head;
        logic       node_rd_next;
        logic       tail_set;
        logic       tail_clr;
        logic       wr_new;
        logic       wr_link;
        logic       clr_next;
        logic       out_load;
        logic [2:0] out_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd_code;
        logic       sweep_done;
        logic       mod_done;
        logic       head_ok;
        logic       node_in_bkt;
        logic       key_match;
        logic       next_ok;
        logic       full;
        logic       out_busy;
    } dp_stat_t;

endpackage

/* rtl/kht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/kht_ctrl.sv */
// Controller state machine: sequences the reset sweep, hashing, chain walk, insert, clear and result.
module kht_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  kht_pkg::dp_stat_t stat,
    output kht_pkg::ctl_cmd_t cmd
);

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_HRD   = 4'd3;
    localparam logic [3:0] S_HWT   = 4'd4;
    localparam logic [3:0] S_NWT   = 4'd5;
    localparam logic [3:0] S_INS1  = 4'd6;
    localparam logic [3:0] S_INS2  = 4'd7;
    localparam logic [3:0] S_CLR   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [2:0] res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
        end else begin
            state_reg <= state_next;
        end
        res_reg <= res_next;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        logic [2:0] miss_status;
        miss_status = (stat.cmd_code != kht_pkg::CMD_INSERT) ? kht_pkg::ST_NOTFOUND :
                      stat.full ? kht_pkg::ST_FULL : kht_pkg::ST_INSERTED;
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.out_status = res_reg;
        case (state_reg)
            S_SWEEP: begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                if (stat.cmd_code == kht_pkg::CMD_CLEAR) begin
                    state_next = S_CLR;
                end else begin
                    cmd.mod_step = 1'b1;
                    if (stat.mod_done) begin
                        state_next = S_HRD;
                    end
                end
            end
            S_HRD: begin
                cmd.head_rd = 1'b1;
                state_next  = S_HWT;
            end
            S_HWT: begin
                if (stat.head_ok) begin
                    cmd.node_rd_head = 1'b1;
                    state_next       = S_NWT;
                end else begin
                    cmd.tail_clr = 1'b1;
                    res_next     = miss_status;
                    state_next   = (miss_status == kht_pkg::ST_INSERTED) ? S_INS1 : S_OUT;
                end
            end
            S_NWT: begin
                if (!stat.node_in_bkt) begin
                    cmd.tail_clr = 1'b1;
                    res_next     = miss_status;
                    state_next   = (miss_status == kht_pkg::ST_INSERTED) ? S_INS1 : S_OUT;
                end else if (stat.key_match) begin
                    res_next   = kht_pkg::ST_FOUND;
                    state_next = S_OUT;
                end else begin
                    cmd.tail_set = 1'b1;
                    if (stat.next_ok) begin
                        cmd.node_rd_next = 1'b1;
                    end else begin
                        res_next   = miss_status;
                        state_next = (miss_status == kht_pkg::ST_INSERTED) ? S_INS1 : S_OUT;
                    end
                end
            end
            S_INS1: begin
                cmd.wr_new = 1'b1;
                state_next = S_INS2;
            end
            S_INS2: begin
                cmd.wr_link = 1'b1;
                state_next  = S_OUT;
            end
            S_CLR: begin
                cmd.clr_next = 1'b1;
                res_next     = kht_pkg::ST_CLEARED;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/kht_datapath.sv */
// Datapath: bucket remainder unit, head and node memories, id counter, result register.
module kht_datapath #(
    parameter int BUCKETS = 1021
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [kht_pkg::KEY_W-1:0]           s_tdata,
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,
    output logic [kht_pkg::STATUS_W-1:0]        m_tuser,
    input  kht_pkg::ctl_cmd_t                   cmd,
    output kht_pkg::dp_stat_t                   stat
);

    localparam int IDX_W   = $clog2(BUCKETS);
    localparam int CNT_W   = $clog2(BUCKETS + 1);
    localparam int REM_W   = IDX_W + 1;
    localparam int KW      = kht_pkg::KEY_W;
    localparam int NODE_W  = KW + IDX_W + 1 + IDX_W;
    localparam int STEPS   = 3;
    localparam int STEP_W  = $clog2(STEPS);
    localparam logic [KW-1:0] RECIP = KW'((64'd1 << KW) / 64'(BUCKETS));

    logic [KW-1:0]     key_reg, mag_reg;
    logic [KW-1:0]     quo_reg, quo_next;
    logic [KW-1:0]     diff_reg, diff_next;
    logic [KW-1:0]     qb;
    logic [1:0]        cmd_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic              tail_reg;
    logic [CNT_W-1:0]  next_id_reg;
    logic [IDX_W-1:0]  sweep_reg;
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;
    logic [kht_pkg::STATUS_W-1:0] m_tuser_reg;

    logic [IDX_W-1:0]  bucket;
    logic              head_we;
    logic [IDX_W-1:0]  head_waddr;
    logic [IDX_W:0]    head_wdata, head_rdata;
    logic              node_we, node_re;
    logic [IDX_W-1:0]  node_waddr, node_raddr;
    logic [NODE_W-1:0] node_wdata, node_rdata;

    logic [KW-1:0]     nd_key;
    logic [IDX_W-1:0]  nd_bkt, nd_next, hd_id;
    logic              nd_nv, hd_v;
    logic [CNT_W-1:0]  nid_m1;
    logic [kht_pkg::ID_W-1:0] res_id;

    assign bucket = rem_reg[IDX_W-1:0];
    assign {hd_v, hd_id} = head_rdata;
    assign {nd_key, nd_bkt, nd_nv, nd_next} = node_rdata;
    assign nid_m1 = next_id_reg - CNT_W'(1);

    // quotient estimate is low by at most one, so one correction step remains
    always_comb begin
        quo_next  = KW'(((2 * KW)'(mag_reg) * (2 * KW)'(RECIP)) >> KW);
        qb        = quo_reg * KW'(BUCKETS);
        diff_next = mag_reg - qb;
        if (diff_reg >= KW'(BUCKETS)) begin
            rem_next = REM_W'(diff_reg - KW'(BUCKETS));
        end else begin
            rem_next = REM_W'(diff_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg  <= s_tdata;
            cmd_reg  <= s_tuser;
            mag_reg  <= s_tdata[KW-1] ? (KW'(0) - s_tdata) : s_tdata;
            rem_reg  <= '0;
            step_reg <= '0;
        end else if (cmd.mod_step) begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(0)) begin
                quo_reg <= quo_next;
            end
            if (step_reg == STEP_W'(1)) begin
                diff_reg <= diff_next;
            end
            if (step_reg == STEP_W'(2)) begin
                rem_reg <= rem_next;
            end
        end
        if (cmd.node_rd_head || cmd.node_rd_next) begin
            cur_reg <= node_raddr;
        end
        if (cmd.tail_set) begin
            tail_reg <= 1'b1;
        end else if (cmd.tail_clr) begin
            tail_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {4'b0, kht_pkg::ID_W'(next_id_reg), res_id};
            m_tuser_reg <= cmd.out_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_id_reg  <= '0;
            sweep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clr_next) begin
                next_id_reg <= '0;
            end else if (cmd.wr_link) begin
                next_id_reg <= next_id_reg + CNT_W'(1);
            end
            if (cmd.sweep_wr) begin
                sweep_reg <= sweep_reg + IDX_W'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        case (cmd.out_status)
            kht_pkg::ST_FOUND:    res_id = kht_pkg::ID_W'(cur_reg);
            kht_pkg::ST_INSERTED: res_id = kht_pkg::ID_W'(nid_m1);
            default:              res_id = '0;
        endcase
    end

    // head entry counts only if it points at a live node of this bucket
    assign head_we    = cmd.sweep_wr || (cmd.wr_link && !tail_reg);
    assign head_waddr = cmd.sweep_wr ? sweep_reg : bucket;
    assign head_wdata = cmd.sweep_wr ? '0 : {1'b1, IDX_W'(next_id_reg)};

    assign node_re    = cmd.node_rd_head || cmd.node_rd_next;
    assign node_raddr = cmd.node_rd_head ? hd_id : nd_next;
    assign node_we    = cmd.wr_new || (cmd.wr_link && tail_reg);
    assign node_waddr = cmd.wr_new ? IDX_W'(next_id_reg) : cur_reg;
    assign node_wdata = cmd.wr_new ? {key_reg, bucket, 1'b0, IDX_W'(0)}
                                   : {nd_key, nd_bkt, 1'b1, IDX_W'(next_id_reg)};

    kht_ram #(.WIDTH(IDX_W + 1), .DEPTH(BUCKETS)) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (cmd.head_rd),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    kht_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    assign stat.cmd_code    = cmd_reg;
    assign stat.sweep_done  = (sweep_reg == IDX_W'(BUCKETS - 1));
    assign stat.mod_done    = (step_reg == STEP_W'(STEPS - 1));
    assign stat.head_ok     = hd_v && (CNT_W'(hd_id) < next_id_reg);
    assign stat.node_in_bkt = (nd_bkt == bucket);
    assign stat.key_match   = (nd_key == key_reg);
    assign stat.next_ok     = nd_nv;
    assign stat.full        = (next_id_reg == CNT_W'(BUCKETS));
    assign stat.out_busy    = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_id_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_id_reg <= CNT_W'(BUCKETS))
        else $error("id counter beyond table size");
    a_new_node_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_new |-> !stat.full)
        else $error("node written with table full");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_step |=> rem_reg < REM_W'(BUCKETS))
        else $error("bucket remainder out of range");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result register overwritten while stalled");

endmodule

/* rtl/key_to_id_hash_table_core.sv */
// Top level of the key-to-id hash table: controller plus datapath.
// Input channel s_*: tdata carries the signed key, tuser the command
// (insert-or-find, lookup, clear). Result channel m_*: tdata carries the id
// and the number of keys stored, tuser the status code. One result per item.
// An item passes the bucket remainder unit in its steps (reciprocal multiply,
// multiply-subtract, correction), then the head read, then the chain walk node
// by node, a write of the new node and then a link write when a new key is
// appended, and last the load of the result register. A clear skips the
// remainder steps, head read and chain walk and goes straight to the result.
// s_tready is low after accept until the result register is loaded, so no new
// item is taken before the last one reaches it. The chain walk sets the rate.
// After reset a clearing pass writes every bucket head, one per cycle;
// s_tready stays low during it. Clear restarts the id counter and stale heads
// are rejected because they point at no live node.
// The result register frees the input side: a new item is taken while a
// result waits; if m_tready stays low the next result holds in its last step.
module key_to_id_hash_table_core #(
    parameter int BUCKETS = 1021
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key[31:0]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // id[9:0], keys_stored[19:10], zero[23:20]
    output logic [2:0]  m_tuser    // status[2:0]
);

    kht_pkg::ctl_cmd_t cmd;
    kht_pkg::dp_stat_t stat;

    kht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kht_datapath #(.BUCKETS(BUCKETS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
